FILE: src/krt_pkg.sv
// shared types and constants of the keyed record table
package krt_pkg;

    localparam int KEY_W       = 16;
    localparam int NAME_LO_W   = 64;
    localparam int NAME_HI_W   = 48;
    localparam int NAME_CHARS  = 14;
    localparam int DUP_W       = 7;
    localparam logic [DUP_W-1:0] DUP_MAX = '1;

    typedef enum logic [1:0] {
        OP_ADD        = 2'd0,
        OP_ADD_UNIQUE = 2'd1,
        OP_FIND       = 2'd2,
        OP_REMOVE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_IDENTICAL = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_CMP,
        ST_APPEND,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_MM_INIT,
        ST_MM_RD,
        ST_MM_USE,
        ST_DP_RD,
        ST_DP_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [NAME_LO_W-1:0] name_lo;
        logic [NAME_HI_W-1:0] name_hi;
    } t_entry;

    typedef struct packed {
        t_status              status;
        logic [3:0]           position;
        logic [4:0]           entry_count;
        logic                 table_nonempty;
        logic [3:0]           min_index;
        logic [3:0]           max_index;
        logic [KEY_W-1:0]     min_key;
        logic [KEY_W-1:0]     max_key;
        logic [DUP_W-1:0]     duplicate_pairs;
    } t_result;

    typedef struct packed {
        logic key_eq;
        logic same;
    } t_cmp;

endpackage

FILE: src/keyed_record_table.sv
// keyed record table top level: stream ports, beat unpacking and output register
//
// channel   dir  tdata                                   tuser
// s (item)  in   key_id, name_low, name_high (128 bits)  op (2 bits)
// m (res)   out  status .. duplicate_pairs (59 of 64)    -
//
// accept to result beat: op work, then a min/max scan and a pair scan over the entries
// held after the op, then the result beat; the pair scan dominates
// op work: add appends, add unless identical first compares each held record, find
// scans until a key hit, remove shifts the later entries down after its find
// s_tready is high only while the sequencer idles; one result waits in the output
// register while the next item runs; reset empties the table (no clearing pass)
module keyed_record_table #(
    parameter int CAPACITY = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] key_id, [79:16] name_low, [127:80] name_high
    input  logic [127:0] s_tdata,
    // [1:0] op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] status, [5:2] position, [10:6] entry_count, [11] table_nonempty,
    // [15:12] min_index, [19:16] max_index, [35:20] min_key, [51:36] max_key,
    // [58:52] duplicate_pairs, [63:59] zero
    output logic [63:0]  m_tdata
);
    import krt_pkg::*;

    t_entry   item;
    t_result  res;
    logic     res_valid;
    logic     res_ready;
    t_result  r_out;
    logic     r_out_valid;

    assign item.key     = s_tdata[15:0];
    assign item.name_lo = s_tdata[79:16];
    assign item.name_hi = s_tdata[127:80];

    krt_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_op        (t_op'(s_tuser)),
        .i_item      (item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'd0, r_out.duplicate_pairs, r_out.max_key, r_out.min_key,
                       r_out.max_index, r_out.min_index, r_out.table_nonempty,
                       r_out.entry_count, r_out.position, r_out.status};

endmodule

FILE: src/krt_cmp.sv
// record compare unit: key match and full record match with terminated names
module krt_cmp (
    input  krt_pkg::t_entry i_a,
    input  krt_pkg::t_entry i_b,
    output krt_pkg::t_cmp   o_cmp
);
    import krt_pkg::*;

    logic [NAME_LO_W+NAME_HI_W-1:0] name_a;
    logic [NAME_LO_W+NAME_HI_W-1:0] name_b;
    logic                           zero_seen;
    logic                           mismatch;
    logic [7:0]                     ch_a;
    logic [7:0]                     ch_b;

    assign name_a = {i_a.name_hi, i_a.name_lo};
    assign name_b = {i_b.name_hi, i_b.name_lo};

    // a character differs before the terminator of name a has been passed
    always_comb begin
        zero_seen = 1'b0;
        mismatch  = 1'b0;
        ch_a      = '0;
        ch_b      = '0;
        for (int c = 0; c < NAME_CHARS; c++) begin
            ch_a = name_a[8*c +: 8];
            ch_b = name_b[8*c +: 8];
            if (!zero_seen && (ch_a != ch_b)) begin
                mismatch = 1'b1;
            end
            if (ch_a == 8'd0) begin
                zero_seen = 1'b1;
            end
        end
    end

    assign o_cmp.key_eq = (i_a.key == i_b.key);
    assign o_cmp.same   = o_cmp.key_eq && !mismatch;

endmodule

FILE: src/krt_seq.sv
// sequencer with record memory: add, find, remove, min/max and duplicate scans
module krt_seq #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  krt_pkg::t_op      i_op,
    input  krt_pkg::t_entry   i_item,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output krt_pkg::t_result  o_res
);
    import krt_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_entry          mem [CAPACITY];

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    t_entry          r_item, n_item;
    logic [CW-1:0]   r_fill, n_fill;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic [IW-1:0]   r_pos, n_pos;
    t_status         r_status, n_status;
    logic [KEY_W-1:0] r_min_k, n_min_k;
    logic [KEY_W-1:0] r_max_k, n_max_k;
    logic [IW-1:0]   r_min_i, n_min_i;
    logic [IW-1:0]   r_max_i, n_max_i;
    logic [DUP_W-1:0] r_dups, n_dups;

    t_entry          r_da;
    t_entry          r_db;
    logic [CW-1:0]   j_next;
    logic [IW-1:0]   rd_a;
    logic [IW-1:0]   rd_b;
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    t_entry          mem_wd;
    t_entry          cmp_b;
    t_cmp            cmp;

    assign j_next = r_j + 1'b1;
    assign rd_a   = (r_state == ST_SH_RD) ? j_next[IW-1:0] : r_i[IW-1:0];
    assign rd_b   = r_j[IW-1:0];
    assign cmp_b  = (r_state == ST_DP_CMP) ? r_db : r_item;

    krt_cmp u_cmp (
        .i_a   (r_da),
        .i_b   (cmp_b),
        .o_cmp (cmp)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_da <= mem[rd_a];
        r_db <= mem[rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_item   <= n_item;
        r_i      <= n_i;
        r_j      <= n_j;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_min_k  <= n_min_k;
        r_max_k  <= n_max_k;
        r_min_i  <= n_min_i;
        r_max_i  <= n_max_i;
        r_dups   <= n_dups;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_item   = r_item;
        n_fill   = r_fill;
        n_i      = r_i;
        n_j      = r_j;
        n_pos    = r_pos;
        n_status = r_status;
        n_min_k  = r_min_k;
        n_max_k  = r_max_k;
        n_min_i  = r_min_i;
        n_max_i  = r_max_i;
        n_dups   = r_dups;
        mem_we   = 1'b0;
        mem_wa   = r_fill[IW-1:0];
        mem_wd   = r_item;
        o_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op     = i_op;
                    n_item   = i_item;
                    n_status = STS_OK;
                    n_pos    = '0;
                    n_i      = '0;
                    unique case (i_op)
                        OP_ADD: n_state = ST_APPEND;
                        OP_ADD_UNIQUE: n_state = (r_fill == '0) ? ST_APPEND : ST_CHK_RD;
                        OP_FIND, OP_REMOVE: begin
                            if (r_fill == '0) begin
                                n_status = STS_NOT_FOUND;
                                n_state  = ST_MM_INIT;
                            end else begin
                                n_state = ST_FIND_RD;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CHK_RD: n_state = ST_CHK_CMP;
            ST_CHK_CMP: begin
                if (cmp.same) begin
                    n_status = STS_IDENTICAL;
                    n_state  = ST_MM_INIT;
                end else if ((r_i + 1'b1) < r_fill) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_CHK_RD;
                end else begin
                    n_state = ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (r_fill == CW'(CAPACITY)) begin
                    n_status = STS_FULL;
                end else begin
                    mem_we = 1'b1;
                    n_fill = r_fill + 1'b1;
                end
                n_state = ST_MM_INIT;
            end
            ST_FIND_RD: n_state = ST_FIND_CMP;
            ST_FIND_CMP: begin
                if (cmp.key_eq) begin
                    n_pos   = r_i[IW-1:0];
                    n_j     = r_i;
                    n_state = (r_op == OP_REMOVE) ? ST_SH_RD : ST_MM_INIT;
                end else if ((r_i + 1'b1) < r_fill) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_FIND_RD;
                end else begin
                    n_status = STS_NOT_FOUND;
                    n_state  = ST_MM_INIT;
                end
            end
            // entry j+1 is read here and written to j in the next cycle
            ST_SH_RD: begin
                if (j_next < r_fill) begin
                    n_state = ST_SH_WR;
                end else begin
                    n_fill  = r_fill - 1'b1;
                    n_state = ST_MM_INIT;
                end
            end
            ST_SH_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_j[IW-1:0];
                mem_wd  = r_da;
                n_j     = j_next;
                n_state = ST_SH_RD;
            end
            ST_MM_INIT: begin
                n_min_k = '0;
                n_max_k = '0;
                n_min_i = '0;
                n_max_i = '0;
                n_dups  = '0;
                n_i     = '0;
                n_state = (r_fill == '0) ? ST_DONE : ST_MM_RD;
            end
            ST_MM_RD: n_state = ST_MM_USE;
            ST_MM_USE: begin
                if (r_i == '0) begin
                    n_min_k = r_da.key;
                    n_max_k = r_da.key;
                end else begin
                    if (r_da.key < r_min_k) begin
                        n_min_k = r_da.key;
                        n_min_i = r_i[IW-1:0];
                    end
                    if (r_da.key > r_max_k) begin
                        n_max_k = r_da.key;
                        n_max_i = r_i[IW-1:0];
                    end
                end
                if ((r_i + 1'b1) < r_fill) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_MM_RD;
                end else begin
                    n_i     = '0;
                    n_j     = CW'(1);
                    n_state = (r_fill == CW'(1)) ? ST_DONE : ST_DP_RD;
                end
            end
            ST_DP_RD: n_state = ST_DP_CMP;
            // pair (i, j) with i < j, one compare per pair
            ST_DP_CMP: begin
                if (cmp.same && (r_dups != DUP_MAX)) begin
                    n_dups = r_dups + 1'b1;
                end
                if (j_next < r_fill) begin
                    n_j     = j_next;
                    n_state = ST_DP_RD;
                end else if ((r_i + 2'd2) < r_fill) begin
                    n_i     = r_i + 1'b1;
                    n_j     = r_i + 2'd2;
                    n_state = ST_DP_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_res.status          = r_status;
        o_res.position        = 4'(r_pos);
        o_res.entry_count     = 5'(r_fill);
        o_res.table_nonempty  = (r_fill != '0);
        o_res.min_index       = 4'(r_min_i);
        o_res.max_index       = 4'(r_max_i);
        o_res.min_key         = r_min_k;
        o_res.max_key         = r_max_k;
        o_res.duplicate_pairs = r_dups;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fill == $past(r_fill)) ||
            (r_fill == $past(r_fill) + 1'b1) || (r_fill == $past(r_fill) - 1'b1))
        else $error("fill count moved by more than one");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == STS_FULL)) |-> (r_fill == CW'(CAPACITY)))
        else $error("full reported on a table with room");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.table_nonempty) |-> (o_res.min_key <= o_res.max_key))
        else $error("min key above max key");

    a_not_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == STS_NOT_FOUND)) |-> (o_res.position == 4'd0))
        else $error("position set on a missed key");

endmodule

FILE: tb/sv/testbench.sv
// self-checking stream testbench for the keyed record table
`timescale 1ns / 1ps

module testbench;
    import krt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 700;
    localparam int LONG_HOLDOFF = 600;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // [15:0] key_id, [79:16] name_low, [127:80] name_high
    logic [127:0] s_tdata  = '0;
    // [1:0] op
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [1:0] status, [5:2] position, [10:6] entry_count, [11] table_nonempty,
    // [15:12] min_index, [19:16] max_index, [35:20] min_key, [51:36] max_key,
    // [58:52] duplicate_pairs
    logic [63:0]  m_tdata;

    // predictor copy of the table
    logic [KEY_W-1:0]     tbl_key [TABLE_DEPTH];
    logic [NAME_LO_W-1:0] tbl_lo  [TABLE_DEPTH];
    logic [NAME_HI_W-1:0] tbl_hi  [TABLE_DEPTH];
    int                   tbl_fill = 0;

    t_result expected_reports[$];
    int      error_count     = 0;
    int      reports_checked = 0;
    int      op_count [4]    = '{0, 0, 0, 0};
    int      full_rejects    = 0;
    int      identical_rejects = 0;
    int      burst_left      = 0;
    int      holdoff_serial  = 0;
    int      cycle_count     = 0;

    keyed_record_table #(
        .CAPACITY (TABLE_DEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // names match up to and including the first zero character
    function automatic logic same_name(logic [NAME_LO_W-1:0] alo, logic [NAME_HI_W-1:0] ahi,
                                       logic [NAME_LO_W-1:0] blo, logic [NAME_HI_W-1:0] bhi);
        logic [111:0] a;
        logic [111:0] b;
        a = {ahi, alo};
        b = {bhi, blo};
        for (int c = 0; c < NAME_CHARS; c++) begin
            if (a[8*c +: 8] != b[8*c +: 8])
                return 1'b0;
            if (a[8*c +: 8] == 8'h00)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic t_result apply_table_op(t_op op, logic [KEY_W-1:0] key,
                                               logic [NAME_LO_W-1:0] lo,
                                               logic [NAME_HI_W-1:0] hi);
        t_result r;
        int      hit;
        int      dups;
        r    = '0;
        hit  = -1;
        dups = 0;
        if (op == OP_ADD || op == OP_ADD_UNIQUE) begin
            if (op == OP_ADD_UNIQUE)
                for (int i = 0; i < tbl_fill; i++)
                    if (tbl_key[i] == key && same_name(tbl_lo[i], tbl_hi[i], lo, hi))
                        hit = i;
            if (hit >= 0) begin
                r.status = STS_IDENTICAL;
            end else if (tbl_fill >= TABLE_DEPTH) begin
                r.status = STS_FULL;
            end else begin
                tbl_key[tbl_fill] = key;
                tbl_lo[tbl_fill]  = lo;
                tbl_hi[tbl_fill]  = hi;
                tbl_fill++;
            end
        end else begin
            for (int i = tbl_fill - 1; i >= 0; i--)
                if (tbl_key[i] == key)
                    hit = i;
            if (hit < 0) begin
                r.status = STS_NOT_FOUND;
            end else begin
                r.position = hit[3:0];
                if (op == OP_REMOVE) begin
                    for (int j = hit; j + 1 < tbl_fill; j++) begin
                        tbl_key[j] = tbl_key[j+1];
                        tbl_lo[j]  = tbl_lo[j+1];
                        tbl_hi[j]  = tbl_hi[j+1];
                    end
                    tbl_fill--;
                end
            end
        end
        r.entry_count = 5'(tbl_fill);
        if (tbl_fill > 0) begin
            r.table_nonempty = 1'b1;
            r.min_key = tbl_key[0];
            r.max_key = tbl_key[0];
            for (int i = 1; i < tbl_fill; i++) begin
                if (tbl_key[i] < r.min_key) begin
                    r.min_key   = tbl_key[i];
                    r.min_index = 4'(i);
                end
                if (tbl_key[i] > r.max_key) begin
                    r.max_key   = tbl_key[i];
                    r.max_index = 4'(i);
                end
            end
            for (int i = 0; i < tbl_fill; i++)
                for (int j = i + 1; j < tbl_fill; j++)
                    if (tbl_key[j] == tbl_key[i] && dups < 127 &&
                        same_name(tbl_lo[j], tbl_hi[j], tbl_lo[i], tbl_hi[i]))
                        dups++;
            r.duplicate_pairs = 7'(dups);
        end
        return r;
    endfunction

    // characters first, first+1 and on, then a terminator if len is below NAME_CHARS, then whatever junk holds
    function automatic logic [111:0] build_name(int len, logic [7:0] first, logic [111:0] junk);
        logic [111:0] nm;
        nm = junk;
        for (int c = 0; c < NAME_CHARS; c++)
            if (c < len)
                nm[8*c +: 8] = first + 8'(c);
            else if (c == len)
                nm[8*c +: 8] = 8'h00;
        return nm;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h0001;
            5:       return 16'h1234;
            6:       return 16'hABCD;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [111:0] pick_name();
        logic [111:0] noise;
        int           len;
        noise = 112'({$urandom, $urandom, $urandom, $urandom});
        len   = $urandom_range(0, 1) ? 4 : $urandom_range(0, NAME_CHARS);
        case ($urandom_range(0, 5))
            0:       return noise;
            1:       return '0;
            default: return build_name(len, $urandom_range(0, 1) ? 8'h41 : 8'h61,
                                       $urandom_range(0, 1) ? noise : '0);
        endcase
    endfunction

    // one item beat: bursts of random length with random gaps in between
    task automatic send_item(t_op op, logic [KEY_W-1:0] key, logic [111:0] nm);
        int      gap;
        t_result r;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 10);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {nm, key};
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        r = apply_table_op(op, key, nm[63:0], nm[111:64]);
        expected_reports.push_back(r);
        op_count[op]++;
        if (r.status == STS_FULL)
            full_rejects++;
        if (r.status == STS_IDENTICAL)
            identical_rejects++;
    endtask

    task automatic send_random_item(int add_pct);
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [111:0]     nm;
        int               idx;
        if ($urandom_range(0, 99) < add_pct)
            op = $urandom_range(0, 1) ? OP_ADD_UNIQUE : OP_ADD;
        else
            op = $urandom_range(0, 1) ? OP_FIND : OP_REMOVE;
        key = pick_key();
        nm  = pick_name();
        if (tbl_fill > 0) begin
            idx = $urandom_range(0, tbl_fill - 1);
            // mostly look up keys that are held; resend held records to hit rejects
            if ((op == OP_FIND || op == OP_REMOVE) && $urandom_range(0, 3) != 0)
                key = tbl_key[idx];
            if (op != OP_FIND && op != OP_REMOVE && $urandom_range(0, 2) == 0) begin
                key = tbl_key[idx];
                nm  = {tbl_hi[idx], tbl_lo[idx]};
            end
        end
        send_item(op, key, nm);
    endtask

    task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result beat with nothing pending: %h", m_tdata);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("status", 16'(want.status), 16'(m_tdata[1:0]));
                check_field("position", 16'(want.position), 16'(m_tdata[5:2]));
                check_field("entry_count", 16'(want.entry_count), 16'(m_tdata[10:6]));
                check_field("table_nonempty", 16'(want.table_nonempty), 16'(m_tdata[11]));
                check_field("min_index", 16'(want.min_index), 16'(m_tdata[15:12]));
                check_field("max_index", 16'(want.max_index), 16'(m_tdata[19:16]));
                check_field("min_key", want.min_key, m_tdata[35:20]);
                check_field("max_key", want.max_key, m_tdata[51:36]);
                check_field("duplicate_pairs", 16'(want.duplicate_pairs), 16'(m_tdata[58:52]));
                reports_checked++;
            end
        end
    end

    // receiver: modes of steady ready, random and periodic stalls, plus a requested long hold-off
    int rx_hold  = 0;
    int rx_left  = 0;
    int rx_mode  = 0;
    int rx_seen  = 0;
    always @(negedge i_clk) begin
        if (rx_seen != holdoff_serial) begin
            rx_seen = holdoff_serial;
            rx_hold = LONG_HOLDOFF;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 2) != 0);
                default: m_tready <= (rx_left % 5 >= 2);
            endcase
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic test_empty_table();
        send_item(OP_FIND, 16'h0000, '0);
        send_item(OP_REMOVE, 16'hFFFF, '1);
    endtask

    // fill with ties, repeats and junk past the terminator, then hit every reject
    task automatic test_fill_and_reject();
        int i;
        send_item(OP_ADD, 16'h8000, build_name(5, 8'h41, '0));
        send_item(OP_ADD, 16'h0000, '0);
        send_item(OP_ADD, 16'hFFFF, '1);
        send_item(OP_ADD, 16'h8000, build_name(5, 8'h41, {14{8'h5A}}));
        send_item(OP_ADD_UNIQUE, 16'h8000, build_name(5, 8'h41, {14{8'h33}}));
        send_item(OP_ADD_UNIQUE, 16'h8000, build_name(6, 8'h41, '0));
        send_item(OP_ADD, 16'h0000, '0);
        send_item(OP_ADD, 16'hFFFF, '1);
        i = 8;
        while (tbl_fill < TABLE_DEPTH) begin
            send_item(OP_ADD_UNIQUE, 16'(i * 16'h0101), build_name(i % 15, 8'h30, {14{8'hA5}}));
            i++;
        end
        send_item(OP_ADD, 16'h1234, build_name(3, 8'h61, '0));
        send_item(OP_ADD_UNIQUE, 16'hFFFF, '1);
        send_item(OP_ADD_UNIQUE, 16'h4321, build_name(3, 8'h61, '0));
    endtask

    task automatic test_find_and_remove();
        send_item(OP_FIND, 16'hFFFF, '0);
        send_item(OP_REMOVE, 16'h8000, '0);
        send_item(OP_REMOVE, tbl_key[tbl_fill-1], '0);
        send_item(OP_ADD_UNIQUE, 16'h8000, build_name(5, 8'h41, {14{8'h77}}));
    endtask

    task automatic test_output_backpressure();
        holdoff_serial++;
        repeat (10) send_random_item(50);
    endtask

    // segments with shifting add bias so the table swings between empty and full
    task automatic test_random_traffic();
        int left;
        int seg;
        int add_pct;
        left = RANDOM_ITEMS;
        while (left > 0) begin
            seg = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       add_pct = 20;
                1:       add_pct = 50;
                default: add_pct = 85;
            endcase
            for (int n = 0; n < seg && left > 0; n++) begin
                send_random_item(add_pct);
                left--;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_fill_and_reject();
        test_find_and_remove();
        test_output_backpressure();
        test_random_traffic();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("items: %0d add, %0d add-unique, %0d find, %0d remove; %0d results checked",
                 op_count[OP_ADD], op_count[OP_ADD_UNIQUE], op_count[OP_FIND],
                 op_count[OP_REMOVE], reports_checked);
        $display("rejects: %0d table full, %0d identical record; %0d cycles",
                 full_rejects, identical_rejects, cycle_count);
        if (error_count == 0 && expected_reports.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
